@@ hw/rtl/vtx_pkg.sv @@
// Shared widths, constants and pipeline types for the vertex transform unit.
`default_nettype none
package vtx_pkg;

  localparam int COEF_FRAC_BITS = 12;
  localparam int NUM_LANES      = 4;
  localparam int COEF_W         = 16;
  localparam int VEC_W          = 32;
  localparam int ROW_W          = NUM_LANES * COEF_W;
  localparam int PROD_W         = COEF_W + VEC_W;
  localparam int ACC_W          = PROD_W + 2;

  localparam int CFG_IDX_W      = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_REGS = CFG_IDX_W'(NUM_LANES);

  localparam logic [VEC_W-1:0] SAT_MAX = {1'b0, {(VEC_W-1){1'b1}}};
  localparam logic [VEC_W-1:0] SAT_MIN = {1'b1, {(VEC_W-1){1'b0}}};

  // Data moved from one cell to the next: running row sums and the vector
  // components not yet consumed (the next one to use sits in vec[0]).
  typedef struct packed {
    logic [NUM_LANES-1:0][ACC_W-1:0] acc;
    logic [NUM_LANES-1:0][VEC_W-1:0] vec;
  } vtx_stage_t;

  typedef struct packed {
    logic [NUM_LANES-1:0][VEC_W-1:0] res;
  } vtx_result_t;

endpackage
`default_nettype wire

@@ hw/rtl/vtx_if.sv @@
// Valid/ready stream interfaces for vertex input and transformed output.
`default_nettype none
interface vtx_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       vec_x;
  logic signed [31:0]       vec_y;
  logic signed [31:0]       vec_z;
  logic signed [31:0]       vec_w;

  modport source (output valid, output vec_x, output vec_y, output vec_z, output vec_w,
                  input ready);
  modport sink   (input valid, input vec_x, input vec_y, input vec_z, input vec_w,
                  output ready);
endinterface

interface vtx_out_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       out_x;
  logic signed [31:0]       out_y;
  logic signed [31:0]       out_z;
  logic signed [31:0]       out_w;

  modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                  input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, input out_w,
                  output ready);
endinterface
`default_nettype wire

@@ hw/rtl/vtx_mac_cell.sv @@
// One column cell: four multiply-accumulates against the head vector component.
`default_nettype none
module vtx_mac_cell (
  input  wire logic                                            clk,
  input  wire logic                                            rst,
  input  wire logic [vtx_pkg::NUM_LANES-1:0][vtx_pkg::COEF_W-1:0] coef,
  input  wire logic                                            in_valid,
  output logic                                                 in_ready,
  input  wire vtx_pkg::vtx_stage_t                             in_data,
  output logic                                                 out_valid,
  input  wire logic                                            out_ready,
  output vtx_pkg::vtx_stage_t                                  out_data
);

  logic [vtx_pkg::NUM_LANES-1:0][vtx_pkg::PROD_W-1:0] prod;
  vtx_pkg::vtx_stage_t                                 stage_next;
  logic [vtx_pkg::VEC_W-1:0]                           vhead;

  assign vhead = in_data.vec[0];

  always_comb begin
    for (int r = 0; r < vtx_pkg::NUM_LANES; r++) begin
      // both operands extended to product width so nothing is lost
      prod[r] = $signed({{vtx_pkg::VEC_W{coef[r][vtx_pkg::COEF_W-1]}}, coef[r]})
              * $signed({{vtx_pkg::COEF_W{vhead[vtx_pkg::VEC_W-1]}}, vhead});
      stage_next.acc[r] = in_data.acc[r]
        + {{(vtx_pkg::ACC_W-vtx_pkg::PROD_W){prod[r][vtx_pkg::PROD_W-1]}}, prod[r]};
    end
    // drop the used component, next one moves to the head
    stage_next.vec = {{vtx_pkg::VEC_W{1'b0}}, in_data.vec[vtx_pkg::NUM_LANES-1:1]};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= stage_next;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/vtx_sat_stage.sv @@
// Output stage: fraction shift, 32-bit saturation and result register.
`default_nettype none
module vtx_sat_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire vtx_pkg::vtx_stage_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output vtx_pkg::vtx_result_t      out_data
);

  localparam int HI_W = vtx_pkg::ACC_W - vtx_pkg::VEC_W + 1;

  logic [vtx_pkg::NUM_LANES-1:0][vtx_pkg::ACC_W-1:0] shifted;
  logic [vtx_pkg::NUM_LANES-1:0][HI_W-1:0]           hi;
  vtx_pkg::vtx_result_t                               res_next;

  always_comb begin
    for (int r = 0; r < vtx_pkg::NUM_LANES; r++) begin
      shifted[r] = $signed(in_data.acc[r]) >>> vtx_pkg::COEF_FRAC_BITS;
      hi[r]      = shifted[r][vtx_pkg::ACC_W-1:vtx_pkg::VEC_W-1];
      // fits when the sign bit of the 32-bit result and all bits above it agree
      if ((&hi[r]) || !(|hi[r])) begin
        res_next.res[r] = shifted[r][vtx_pkg::VEC_W-1:0];
      end else if (shifted[r][vtx_pkg::ACC_W-1]) begin
        res_next.res[r] = vtx_pkg::SAT_MIN;
      end else begin
        res_next.res[r] = vtx_pkg::SAT_MAX;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= res_next;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/vertex_transform_4x4_unit.sv @@
// Top level: 4x4 fixed-point matrix times vertex, as a chain of column cells.
//
//  channel     | dir | beat payload                         | handshake
//  ------------+-----+--------------------------------------+------------
//  vertex_in   | in  | vec_x, vec_y, vec_z, vec_w  (Q16.16) | valid/ready
//  vertex_out  | out | out_x, out_y, out_z, out_w  (Q16.16) | valid/ready
//  cfg         | in  | cfg_index (row 0..3), cfg_data       | cfg_we only
//
// One vertex beat per clock sustained while vertex_out is ready; a beat
// accepted reaches vertex_out through five registers: four column cells
// (one per vector component) then the shift/saturate output register.
// Synchronous rst clears the stage valids and the matrix rows to zero.
// Each cell has its own valid and a local ready, so bubbles are squeezed out
// and up to five beats are held while vertex_out stalls.
// Rows may only be rewritten with the pipeline empty.
`default_nettype none
module vertex_transform_4x4_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [vtx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [vtx_pkg::ROW_W-1:0]       cfg_data,
  vtx_in_if.sink                               vertex_in,
  vtx_out_if.source                            vertex_out
);

  localparam int NL = vtx_pkg::NUM_LANES;

  // matrix rows, column 0 in the low coefficient
  logic [NL-1:0][vtx_pkg::ROW_W-1:0] rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= '0;
    end else if (cfg_we && (cfg_index < vtx_pkg::CFG_NUM_REGS)) begin
      rows[cfg_index[$clog2(NL)-1:0]] <= cfg_data;
    end
  end

  // coefficient column c for every row, fed to cell c
  logic [NL-1:0][NL-1:0][vtx_pkg::COEF_W-1:0] coef_col;

  always_comb begin
    for (int c = 0; c < NL; c++) begin
      for (int r = 0; r < NL; r++) begin
        coef_col[c][r] = rows[r][vtx_pkg::COEF_W*c +: vtx_pkg::COEF_W];
      end
    end
  end

  // chain links: link 0 is the input beat, link NL feeds the output stage
  vtx_pkg::vtx_stage_t chain_data  [NL+1];
  logic                chain_valid [NL+1];
  logic                chain_ready [NL+1];

  assign chain_valid[0]      = vertex_in.valid;
  assign vertex_in.ready     = chain_ready[0];
  assign chain_data[0].acc   = '0;
  assign chain_data[0].vec   = {vertex_in.vec_w, vertex_in.vec_z,
                                vertex_in.vec_y, vertex_in.vec_x};

  for (genvar c = 0; c < NL; c++) begin : g_cell
    vtx_mac_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .coef      (coef_col[c]),
      .in_valid  (chain_valid[c]),
      .in_ready  (chain_ready[c]),
      .in_data   (chain_data[c]),
      .out_valid (chain_valid[c+1]),
      .out_ready (chain_ready[c+1]),
      .out_data  (chain_data[c+1])
    );
  end

  vtx_pkg::vtx_result_t result;

  vtx_sat_stage u_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chain_valid[NL]),
    .in_ready  (chain_ready[NL]),
    .in_data   (chain_data[NL]),
    .out_valid (vertex_out.valid),
    .out_ready (vertex_out.ready),
    .out_data  (result)
  );

  assign vertex_out.out_x = result.res[0];
  assign vertex_out.out_y = result.res[1];
  assign vertex_out.out_z = result.res[2];
  assign vertex_out.out_w = result.res[3];

  // beats held inside the block, for the checks below
  logic [2:0] occupancy;
  logic       in_fire;
  logic       out_fire;

  assign in_fire  = vertex_in.valid && vertex_in.ready;
  assign out_fire = vertex_out.valid && vertex_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (in_fire && !out_fire) begin
      occupancy <= occupancy + 3'd1;
    end else if (out_fire && !in_fire) begin
      occupancy <= occupancy - 3'd1;
    end
  end

  // never more beats than registers in the chain
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= 3'd5)
    else $error("occupancy above chain depth");

  // every held beat sits in exactly one stage register
  a_occ_match: assert property (@(posedge clk) disable iff (rst)
    occupancy == 3'($countones({chain_valid[1], chain_valid[2], chain_valid[3],
                                chain_valid[4], vertex_out.valid})))
    else $error("stage valids disagree with beat count");

  // an empty output register means the chain can take a beat
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !vertex_out.valid |-> vertex_in.ready)
    else $error("input stalled with output free");

  // a result appears only for a beat accepted earlier
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    vertex_out.valid |-> occupancy != 3'd0)
    else $error("result without accepted beat");

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench for the 4x4 fixed-point vertex transform: stream stimulus, predictor, checker.
`timescale 1ns / 1ps

module tb_top;

  import vtx_pkg::*;

  // Extra wait in drain() after the last owed result, with a little slack.
  localparam int XFORM_LATENCY = 4 + 2;
  // Cycles without any beat or register write before the run is abandoned.
  localparam int STALL_LIMIT   = 2000;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_BEATS   = 125;
  localparam int IDLE_PERCENT  = 37;
  localparam int MAX_CFG_INDEX = (1 << CFG_IDX_W) - 1;

  localparam logic signed [VEC_W-1:0] VMAX = 32'sh7FFF_FFFF;
  localparam logic signed [VEC_W-1:0] VMIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
    logic signed [VEC_W-1:0] w;
  } vec4_t;

  function automatic logic signed [VEC_W-1:0] lane(vec4_t v, int i);
    case (i)
      0: return v.x;
      1: return v.y;
      2: return v.z;
      default: return v.w;
    endcase
  endfunction

  // Own copy of the matrix, and the transformed vertices still owed by the block.
  class xform_tracker;
    logic [ROW_W-1:0] rows [NUM_LANES];
    vec4_t            pending_xforms [$];
    int               mismatches;

    function new();
      foreach (rows[r]) rows[r] = '0;
      mismatches = 0;
    endfunction

    function void load_row(int unsigned idx, logic [ROW_W-1:0] data);
      if (idx < NUM_LANES) rows[idx] = data;
    endfunction

    // Full-width dot product, arithmetic shift (floor), clamp to 32 bits.
    function logic signed [VEC_W-1:0] dot_row(int r, vec4_t v);
      longint                   acc;
      logic signed [COEF_W-1:0] coef;
      acc = 0;
      for (int c = 0; c < NUM_LANES; c++) begin
        coef = rows[r][COEF_W*c +: COEF_W];
        acc += longint'(coef) * longint'(lane(v, c));
      end
      acc = acc >>> COEF_FRAC_BITS;
      if (acc > longint'(VMAX)) return VMAX;
      if (acc < longint'(VMIN)) return VMIN;
      return acc[VEC_W-1:0];
    endfunction

    function void note_vertex(vec4_t v);
      pending_xforms.push_back(vec4_t'{dot_row(0, v), dot_row(1, v),
                                       dot_row(2, v), dot_row(3, v)});
    endfunction

    function int pending();
      return pending_xforms.size();
    endfunction

    task report(string what);
      $display("%0t ns: mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(vec4_t got);
      vec4_t want;
      if (pending_xforms.size() == 0) begin
        report($sformatf("result beat %h with nothing outstanding", got));
      end else begin
        want = pending_xforms.pop_front();
        for (int i = 0; i < NUM_LANES; i++)
          if (lane(got, i) !== lane(want, i))
            report($sformatf("lane %0d got %0d (%h) expected %0d (%h)", i,
                             lane(got, i), lane(got, i), lane(want, i), lane(want, i)));
      end
    endtask

    task close();
      if (pending_xforms.size() != 0)
        report($sformatf("%0d transformed vertices never came out", pending_xforms.size()));
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ROW_W-1:0]     cfg_data;
  bit                   quiet;        // suppresses idling on both sides
  int                   stall_cycles;

  xform_tracker tracker = new();

  vtx_in_if  vin ();
  vtx_out_if vout ();

  vertex_transform_4x4_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .vertex_in  (vin),
    .vertex_out (vout)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Random content
  // ---------------------------------------------------------------------------

  // kind 0: any 32-bit pattern, 1: near zero, 2: corner values.
  function automatic logic signed [VEC_W-1:0] rand_comp(int kind);
    case (kind)
      0: return $urandom;
      1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      default: begin
        case ($urandom_range(0, 5))
          0: return VMAX;
          1: return VMIN;
          2: return 32'sd0;
          3: return -32'sd1;
          4: return 32'sd1;
          default: return 32'sh0001_0000;
        endcase
      end
    endcase
  endfunction

  // kind 3 mixes the other kinds lane by lane.
  function automatic vec4_t rand_vertex();
    int kind;
    kind = $urandom_range(0, 3);
    return vec4_t'{rand_comp(kind == 3 ? $urandom_range(0, 2) : kind),
                   rand_comp(kind == 3 ? $urandom_range(0, 2) : kind),
                   rand_comp(kind == 3 ? $urandom_range(0, 2) : kind),
                   rand_comp(kind == 3 ? $urandom_range(0, 2) : kind)};
  endfunction

  // kind 0: any pattern, 1: within +-1.0, 2: corner coefficients.
  function automatic logic [COEF_W-1:0] rand_coef(int kind);
    case (kind)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 16'h2000)) - 16'h1000;
      default: begin
        case ($urandom_range(0, 5))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          3: return 16'h1000;
          4: return 16'hF000;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  function automatic logic [ROW_W-1:0] rand_row();
    logic [ROW_W-1:0] r;
    int               kind;
    kind = $urandom_range(0, 3);
    for (int c = 0; c < NUM_LANES; c++)
      r[COEF_W*c +: COEF_W] = rand_coef(kind == 3 ? $urandom_range(0, 2) : kind);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. All tasks are entered just after a rising edge and drive with
  // nonblocking assignments, so the block sees stable values at the next edge.
  // ---------------------------------------------------------------------------

  task automatic write_row(int unsigned idx, logic [ROW_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= data;
    tracker.load_row(idx, data);
    @(posedge clk);
  endtask

  // Loads all four rows, then a stray write to an unused index which the block
  // must ignore. The write enable is only lowered after the last one.
  task automatic set_matrix(logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1,
                            logic [ROW_W-1:0] r2, logic [ROW_W-1:0] r3);
    write_row(0, r0);
    write_row(1, r1);
    write_row(2, r2);
    write_row(3, r3);
    write_row($urandom_range(NUM_LANES, MAX_CFG_INDEX), {$urandom, $urandom});
    cfg_we <= 1'b0;
  endtask

  // One input beat. With hold set, the sender first stays quiet until every
  // owed result has come out; otherwise each cycle may be an idle one.
  // valid stays high across back-to-back beats.
  task automatic feed(vec4_t v, bit hold = 1'b0);
    if (hold) begin
      vin.valid <= 1'b0;
      do @(posedge clk); while (tracker.pending() != 0);
    end else begin
      while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
        vin.valid <= 1'b0;
        @(posedge clk);
      end
    end
    vin.valid <= 1'b1;
    vin.vec_x <= v.x;
    vin.vec_y <= v.y;
    vin.vec_z <= v.z;
    vin.vec_w <= v.w;
    do @(posedge clk); while (!vin.ready);
    tracker.note_vertex(v);
  endtask

  // Empties the pipe before a matrix change: no beat outstanding, then the
  // latency again so nothing is still in flight.
  task automatic drain();
    vin.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    repeat (XFORM_LATENCY) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: check each accepted beat, then pick ready for the next cycle.
  // Values are read straight after the edge, before any register updates land.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && vout.valid && vout.ready)
      tracker.check_result(vec4_t'{vout.out_x, vout.out_y, vout.out_z, vout.out_w});
    vout.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Watchdog: any beat, register write or reset cycle restarts the count.
  always @(posedge clk) begin
    if (rst || cfg_we || (vin.valid && vin.ready) || (vout.valid && vout.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("vertex_transform_4x4_unit test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int pause_at;

    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    quiet        = 1'b0;
    stall_cycles = 0;
    vin.valid    = 1'b0;
    vin.vec_x    = '0;
    vin.vec_y    = '0;
    vin.vec_z    = '0;
    vin.vec_w    = '0;
    vout.ready   = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Matrix straight out of reset is all zero: every lane must read zero.
    feed(vec4_t'{32'sd0, 32'sd0, 32'sd0, 32'sd0});
    feed(vec4_t'{VMAX, VMAX, VMAX, VMAX});
    feed(vec4_t'{VMIN, VMIN, VMIN, VMIN});
    drain();

    // Identity: vertices pass through untouched.
    set_matrix(64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
               64'h0000_1000_0000_0000, 64'h1000_0000_0000_0000);
    feed(vec4_t'{32'sd1, -32'sd1, VMAX, VMIN});
    feed(vec4_t'{32'sh0001_2345, -32'sh0001_2345, 32'sh7FFF_0000, -32'sh0001_0000});
    drain();

    // Half on the diagonal: odd negatives must floor, not round towards zero.
    set_matrix(64'h0000_0000_0000_0800, 64'h0000_0000_0800_0000,
               64'h0000_0800_0000_0000, 64'h0800_0000_0000_0000);
    feed(vec4_t'{-32'sd1, 32'sd1, -32'sd3, 32'sd3});
    feed(vec4_t'{VMIN, VMAX, -32'sd1, 32'sd1});
    drain();

    // Largest positive coefficients: saturation at both ends.
    set_matrix({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
    feed(vec4_t'{VMAX, VMAX, VMAX, VMAX});
    feed(vec4_t'{VMIN, VMIN, VMIN, VMIN});
    feed(vec4_t'{VMAX, VMIN, VMAX, VMIN});
    drain();

    // Most negative coefficients: sign flips into saturation, small negatives.
    set_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
    feed(vec4_t'{VMAX, VMAX, VMAX, VMAX});
    feed(vec4_t'{VMIN, VMIN, VMIN, VMIN});
    feed(vec4_t'{-32'sd1, -32'sd1, -32'sd1, -32'sd1});
    drain();

    // Distinct rows so a lane swap would show.
    set_matrix(64'h7FFF_8000_0001_FFFF, 64'h1000_F000_0800_0000,
               rand_row(), rand_row());
    feed(vec4_t'{32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000});
    feed(rand_vertex());

    // Random phases, each under its own matrix. The first two use the extreme
    // matrices; one phase runs with no idling at all. Each phase has one point
    // where the sender waits for the output to run dry.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      case (ph)
        0: set_matrix({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
        1: set_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
        default: set_matrix(rand_row(), rand_row(), rand_row(), rand_row());
      endcase
      quiet    = (ph == 3);
      pause_at = $urandom_range(10, PHASE_BEATS - 10);
      for (int i = 0; i < PHASE_BEATS; i++)
        feed(rand_vertex(), i == pause_at);
    end
    quiet = 1'b0;

    drain();
    tracker.close();
    if (tracker.mismatches == 0) begin
      $display("vertex_transform_4x4_unit test passed");
    end else begin
      $display("vertex_transform_4x4_unit test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/vtx_pkg.sv
hw/rtl/vtx_if.sv
hw/rtl/vtx_mac_cell.sv
hw/rtl/vtx_sat_stage.sv
hw/rtl/vertex_transform_4x4_unit.sv
sim/tb_top.sv
